// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the divider rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sd128_pkg.sv =====
// shared types and constants for the signed 128-bit divider
// no dependencies
`timescale 1ns / 1ps

package sd128_pkg;

    localparam int FIELD_W = 64;
    localparam int FULL_W  = 2 * FIELD_W;
    localparam int TDATA_W = 4 * FIELD_W;

    // control word that travels with each operand pair down the chain
    typedef struct packed {
        logic valid;
        logic dvd_neg;
        logic dvs_neg;
        logic dvs_zero;
    } t_sd_ctl;

endpackage

// ===== hw/rtl/sd128_front.sv =====
// input stage: sign capture and operand magnitudes
// depends on sd128_pkg
`timescale 1ns / 1ps

module sd128_front
    import sd128_pkg::*;
#(
    parameter int W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [FULL_W-1:0] i_dividend,
    input  logic [FULL_W-1:0] i_divisor,
    output t_sd_ctl           o_ctl,
    output logic [W-1:0]      o_num,
    output logic [W-1:0]      o_den
);

    logic [W-1:0] dvd_w;
    logic [W-1:0] dvs_w;
    t_sd_ctl      n_ctl;
    logic [W-1:0] n_num;
    logic [W-1:0] n_den;
    t_sd_ctl      r_ctl;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;

    always_comb begin
        dvd_w          = i_dividend[W-1:0];
        dvs_w          = i_divisor[W-1:0];
        n_ctl.valid    = i_valid;
        n_ctl.dvd_neg  = dvd_w[W-1];
        n_ctl.dvs_neg  = dvs_w[W-1];
        n_ctl.dvs_zero = (dvs_w == '0);
        // two's complement magnitude; the most negative value maps onto itself unsigned
        n_num = dvd_w[W-1] ? (~dvd_w + W'(1)) : dvd_w;
        n_den = dvs_w[W-1] ? (~dvs_w + W'(1)) : dvs_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

// ===== hw/rtl/sd128_cell.sv =====
// one division step: shift in a dividend bit, trial subtract, keep quotient bit
// depends on sd128_pkg
`timescale 1ns / 1ps

module sd128_cell
    import sd128_pkg::*;
#(
    parameter int W = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_sd_ctl      i_ctl,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_nq,
    input  logic [W-1:0] i_den,
    output t_sd_ctl      o_ctl,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_nq,
    output logic [W-1:0] o_den
);

    // nq holds the unused dividend bits at the top and the quotient bits at the bottom
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         take;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_nq;
    t_sd_ctl      r_ctl;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_nq;
    logic [W-1:0] r_den;

    always_comb begin
        shifted = {i_rem, i_nq[W-1]};
        diff    = shifted - {1'b0, i_den};
        take    = (shifted >= {1'b0, i_den});
        n_rem   = take ? diff[W-1:0] : shifted[W-1:0];
        n_nq    = {i_nq[W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_den = r_den;

endmodule

// ===== hw/rtl/sd128_back.sv =====
// output stage: sign correction, sign extension and zero-divisor override
// depends on sd128_pkg
`timescale 1ns / 1ps

module sd128_back
    import sd128_pkg::*;
#(
    parameter int W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_sd_ctl           i_ctl,
    input  logic [W-1:0]      i_rem,
    input  logic [W-1:0]      i_quot,
    output t_sd_ctl           o_ctl,
    output logic [FULL_W-1:0] o_quot,
    output logic [FULL_W-1:0] o_rem
);

    logic [W-1:0]      quot_w;
    logic [W-1:0]      rem_w;
    logic [FULL_W-1:0] n_quot;
    logic [FULL_W-1:0] n_rem;
    t_sd_ctl           r_ctl;
    logic [FULL_W-1:0] r_quot;
    logic [FULL_W-1:0] r_rem;

    always_comb begin
        quot_w = (i_ctl.dvd_neg ^ i_ctl.dvs_neg) ? (~i_quot + W'(1)) : i_quot;
        // remainder follows the dividend; with a zero divisor this rebuilds the dividend
        rem_w  = i_ctl.dvd_neg ? (~i_rem + W'(1)) : i_rem;
        n_quot = i_ctl.dvs_zero ? '1 : FULL_W'($signed(quot_w));
        n_rem  = FULL_W'($signed(rem_w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/signed_divider_128.sv =====
// signed 128-bit divider, top level: stream ports, cell chain and output skid
// depends on sd128_pkg, sd128_front, sd128_cell, sd128_back, assert_macros.svh
`timescale 1ns / 1ps
// usage
//  - slave channel carries one operand pair per transfer: dividend and divisor,
//    each as a low and a signed high 64-bit half
//  - master channel returns quotient (truncated toward zero) and remainder
//    (sign of the dividend) in tdata, divide-by-zero flag in tuser
//  - the operands are read as DATA_WIDTH-bit two's complement numbers, upper
//    input bits ignored, results sign-extended to 128 bits
//  - throughput: one transfer per clock on each side while the receiver keeps up
//  - path: from the accepting edge to o_m_axis_tvalid a result passes the magnitude
//    stage, the chain of DATA_WIDTH step cells, one quotient bit per cell, the
//    sign-fix stage and the output register
//  - zero divisor: flag set, quotient all ones, remainder the dividend
//  - most negative over minus one wraps to the most negative value
//  - reset (synchronous, active low) empties the chain and the output stage;
//    no result is lost or duplicated across a stall
//  - receiver stall: the result waiting in the output register is held and the
//    next one drops into a skid register; only when that is full does the whole
//    chain freeze and o_s_axis_tready go low
module signed_divider_128
    import sd128_pkg::*;
#(
    parameter int DATA_WIDTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // dividend_low, dividend_high, divisor_low, divisor_high (lowest bits first)
    input  logic [TDATA_W-1:0] i_s_axis_tdata,
    // master side
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // quotient_low, quotient_high, remainder_low, remainder_high (lowest bits first)
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    // divide_by_zero
    output logic               o_m_axis_tuser
);

    localparam int W = DATA_WIDTH;

    // chain advances as one while the skid register is free
    logic en;

    t_sd_ctl      front_ctl;
    logic [W-1:0] front_num;
    logic [W-1:0] front_den;

    // node k feeds cell k, node W is the tail of the chain
    t_sd_ctl      chain_ctl [0:W];
    logic [W-1:0] chain_rem [0:W];
    logic [W-1:0] chain_nq  [0:W];
    logic [W-1:0] chain_den [0:W];

    t_sd_ctl           back_ctl;
    logic [FULL_W-1:0] back_quot;
    logic [FULL_W-1:0] back_rem;

    logic new_valid;
    logic out_take;

    logic              r_out_valid;
    logic [FULL_W-1:0] r_out_quot;
    logic [FULL_W-1:0] r_out_rem;
    logic              r_out_zero;
    logic              r_skid_valid;
    logic [FULL_W-1:0] r_skid_quot;
    logic [FULL_W-1:0] r_skid_rem;
    logic              r_skid_zero;

    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    sd128_front #(
        .W (W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_axis_tvalid),
        .i_dividend (i_s_axis_tdata[FULL_W-1:0]),
        .i_divisor  (i_s_axis_tdata[TDATA_W-1:FULL_W]),
        .o_ctl      (front_ctl),
        .o_num      (front_num),
        .o_den      (front_den)
    );

    // partial remainder starts at zero, dividend magnitude enters at the top of nq
    assign chain_ctl[0] = front_ctl;
    assign chain_rem[0] = '0;
    assign chain_nq[0]  = front_num;
    assign chain_den[0] = front_den;

    for (genvar k = 0; k < W; k++) begin : g_cell
        sd128_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (chain_ctl[k]),
            .i_rem   (chain_rem[k]),
            .i_nq    (chain_nq[k]),
            .i_den   (chain_den[k]),
            .o_ctl   (chain_ctl[k+1]),
            .o_rem   (chain_rem[k+1]),
            .o_nq    (chain_nq[k+1]),
            .o_den   (chain_den[k+1])
        );
    end

    sd128_back #(
        .W (W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (chain_ctl[W]),
        .i_rem   (chain_rem[W]),
        .i_quot  (chain_nq[W]),
        .o_ctl   (back_ctl),
        .o_quot  (back_quot),
        .o_rem   (back_rem)
    );

    assign new_valid = back_ctl.valid && en;
    assign out_take  = r_out_valid && i_m_axis_tready;

    // output register with skid: a stalled receiver costs one slot before backpressure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= new_valid;
            end
        end else if (new_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_quot <= r_skid_quot;
                r_out_rem  <= r_skid_rem;
                r_out_zero <= r_skid_zero;
            end else if (new_valid) begin
                r_out_quot <= back_quot;
                r_out_rem  <= back_rem;
                r_out_zero <= back_ctl.dvs_zero;
            end
        end else if (new_valid) begin
            r_skid_quot <= back_quot;
            r_skid_rem  <= back_rem;
            r_skid_zero <= back_ctl.dvs_zero;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_rem, r_out_quot};
    assign o_m_axis_tuser  = r_out_zero;

`include "assert_macros.svh"

    `SD_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds a result while the output register is empty")
    `SD_ASSERT_IMPL(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid),
        $past(r_out_valid && !i_m_axis_tready), "skid filled without a stalled output")
    `SD_ASSERT_IMPL(a_zero_quot_ones, i_clk, i_rst_n, r_out_valid && r_out_zero,
        r_out_quot == '1, "zero divisor without an all-ones quotient")
    `SD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_m_axis_tready,
        !r_skid_valid && r_out_valid, "skid did not drain into the output register")

endmodule
